@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHECK_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define CHECK_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

@@ sv/wwst_pkg.sv @@
`timescale 1ns / 1ps
package wwst_pkg;
   localparam int MAX_MAP_WIDTH = 256;
   localparam int MAX_MAP_HEIGHT = 256;
   localparam int COL_W = $clog2(MAX_MAP_WIDTH);
   localparam int ROW_W = $clog2(MAX_MAP_HEIGHT);
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int DEPTH = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
   localparam int SUM_W = 48;
   localparam int ROWSUM_W = 40;
   localparam int CSR_W = 9;
   localparam logic [1:0] CSR_MAP_WIDTH = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_SUPPLY_RADIUS = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [31:0] cell_value;
      logic [7:0]  site_x;
      logic [7:0]  site_y;
      logic [5:0]  offset_x;
      logic [5:0]  offset_y;
      logic [5:0]  foot_width;
      logic [5:0]  foot_height;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD_RD, ST_LOAD_WAIT, ST_LOAD_WR, ST_Q_MOD, ST_Q_PREP, ST_Q_RD,
      ST_Q_ACC, ST_Q_DONE
   } state_type;
endpackage

@@ sv/wwst_ram.sv @@
`timescale 1ns / 1ps
module wwst_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ sv/wwst_front.sv @@
`timescale 1ns / 1ps
module wwst_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_full,
   input  wwst_pkg::item_type  in_item,
   output logic                q_valid,
   input  logic                q_take,
   output wwst_pkg::item_type  q_item
);
   logic [1:0] count_ff, count_in;
   logic rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   wwst_pkg::item_type slot_ff [2];
   logic push_ok, pop_ok;

   assign in_full = count_ff == 2'd2;
   assign q_valid = count_ff != 2'd0;
   assign q_item = slot_ff[rd_ptr_ff];
   assign push_ok = in_valid && !in_full;
   assign pop_ok = q_take && q_valid;

   always_comb begin
      count_in = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

@@ sv/wwst_back.sv @@
`timescale 1ns / 1ps
module wwst_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_take,
   input  wwst_pkg::item_type          q_item,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [wwst_pkg::CSR_W-1:0]  csr_data,
   output logic                        out_valid,
   output logic [wwst_pkg::SUM_W-1:0]  out_sum,
   input  logic                        out_pop
);
   localparam int CW = wwst_pkg::COL_W;
   localparam int RW = wwst_pkg::ROW_W;
   localparam int AW = wwst_pkg::ADDR_W;
   localparam int SW = wwst_pkg::SUM_W;

   wwst_pkg::state_type state_ff, state_in;
   logic [8:0] width_ff, height_ff;
   logic [6:0] radius_ff;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [wwst_pkg::ROWSUM_W-1:0] rsum_ff;
   wwst_pkg::item_type item_ff;
   logic [10:0] w_eff, h_eff;
   logic [10:0] spx_ff, spy_ff, sx_ff, sy_ff, fw_ff, fh_ff;
   logic [16:0] mx_ff, my_ff, dx_ff, dy_ff;
   logic [3:0] mstep_ff;
   logic [10:0] mxs, mys;
   logic [3:0] k_ff;
   logic [SW-1:0] acc_ff;
   logic [SW-1:0] res_ff;
   logic res_valid_ff;
   logic hit_ff;
   logic neg_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [SW-1:0] rd_data, wr_data;
   logic wr_en;
   logic [10:0] cr, cc;
   logic cr_hit, cc_hit;
   logic [1:0] piece;
   logic [10:0] px0, py0, pw, ph;
   logic [10:0] reach;
   logic signed [12:0] rawx, rawy;
   logic [10:0] spxr, spyr;

   assign w_eff = (width_ff > 9'(wwst_pkg::MAX_MAP_WIDTH)) ?
                  11'(wwst_pkg::MAX_MAP_WIDTH) : {2'b0, width_ff};
   assign h_eff = (height_ff > 9'(wwst_pkg::MAX_MAP_HEIGHT)) ?
                  11'(wwst_pkg::MAX_MAP_HEIGHT) : {2'b0, height_ff};
   assign reach = {4'b0, radius_ff} + 11'd1;
   assign rawx = $signed({5'b0, q_item.site_x}) + 13'($signed(q_item.offset_x))
               - $signed({2'b0, reach});
   assign rawy = $signed({5'b0, q_item.site_y}) + 13'($signed(q_item.offset_y))
               - $signed({2'b0, reach});
   assign spxr = {5'b0, q_item.foot_width} + {reach[9:0], 1'b0};
   assign spyr = {5'b0, q_item.foot_height} + {reach[9:0], 1'b0};
   assign mxs = mx_ff[10:0];
   assign mys = my_ff[10:0];

   // Corner k: piece k>>2, corner k&3 (yb,xb / ya,xb / yb,xa / ya,xa).
   always_comb begin
      piece = k_ff[3:2];
      px0 = piece[0] ? 11'd0 : sx_ff;
      py0 = piece[1] ? 11'd0 : sy_ff;
      pw = piece[0] ? spx_ff - fw_ff : fw_ff;
      ph = piece[1] ? spy_ff - fh_ff : fh_ff;
      cr = k_ff[0] ? py0 : py0 + ph;
      cc = k_ff[1] ? px0 : px0 + pw;
      cr_hit = (pw != 0) && (ph != 0) && (cr != 0) && (cc != 0)
               && (cr <= 11'(wwst_pkg::MAX_MAP_HEIGHT))
               && (cc <= 11'(wwst_pkg::MAX_MAP_WIDTH));
      cc_hit = k_ff[0] ^ k_ff[1];
   end

   always_comb begin
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = {row_ff, col_ff};
      wr_data = rd_data + {{(SW - wwst_pkg::ROWSUM_W){1'b0}}, rsum_ff};
      if (state_ff == wwst_pkg::ST_LOAD_RD || state_ff == wwst_pkg::ST_LOAD_WAIT) begin
         rd_addr = {row_ff - RW'(1), col_ff};
      end else if (state_ff == wwst_pkg::ST_Q_RD) begin
         rd_addr = {RW'(cr - 11'd1), CW'(cc - 11'd1)};
      end
      if (state_ff == wwst_pkg::ST_LOAD_WR) begin
         wr_en = 1'b1;
         if (row_ff == '0) begin
            wr_data = {{(SW - wwst_pkg::ROWSUM_W){1'b0}}, rsum_ff};
         end
      end
   end

   wwst_ram #(.WIDTH(SW), .DEPTH(wwst_pkg::DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wwst_pkg::ST_IDLE: begin
            if (q_valid && (!res_valid_ff || !q_item.mode)) begin
               if (!q_item.mode) begin
                  state_in = (w_eff == 0 || h_eff == 0) ? wwst_pkg::ST_IDLE
                                                        : wwst_pkg::ST_LOAD_RD;
               end else begin
                  state_in = (w_eff == 0 || h_eff == 0) ? wwst_pkg::ST_Q_DONE
                                                        : wwst_pkg::ST_Q_MOD;
               end
            end
         end
         wwst_pkg::ST_LOAD_RD:   state_in = wwst_pkg::ST_LOAD_WAIT;
         wwst_pkg::ST_LOAD_WAIT: state_in = wwst_pkg::ST_LOAD_WR;
         wwst_pkg::ST_LOAD_WR:   state_in = wwst_pkg::ST_IDLE;
         wwst_pkg::ST_Q_MOD:     state_in = (mstep_ff == 4'd8) ? wwst_pkg::ST_Q_PREP
                                                               : wwst_pkg::ST_Q_MOD;
         wwst_pkg::ST_Q_PREP:    state_in = wwst_pkg::ST_Q_RD;
         wwst_pkg::ST_Q_RD:      state_in = wwst_pkg::ST_Q_ACC;
         wwst_pkg::ST_Q_ACC:     state_in = (k_ff == 4'd15) ? wwst_pkg::ST_Q_DONE
                                                            : wwst_pkg::ST_Q_RD;
         wwst_pkg::ST_Q_DONE:    state_in = wwst_pkg::ST_IDLE;
         default:                state_in = wwst_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_take = (state_ff == wwst_pkg::ST_IDLE) && q_valid
               && (!res_valid_ff || !q_item.mode);
   end

   assign out_valid = res_valid_ff;
   assign out_sum = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wwst_pkg::ST_IDLE;
         width_ff <= 9'd256;
         height_ff <= 9'd256;
         radius_ff <= 7'd12;
         col_ff <= '0;
         row_ff <= '0;
         rsum_ff <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_pop && res_valid_ff) begin
            res_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               wwst_pkg::CSR_MAP_WIDTH: begin
                  width_ff <= csr_data;
                  col_ff <= '0; row_ff <= '0; rsum_ff <= '0;
               end
               wwst_pkg::CSR_MAP_HEIGHT: begin
                  height_ff <= csr_data;
                  col_ff <= '0; row_ff <= '0; rsum_ff <= '0;
               end
               wwst_pkg::CSR_SUPPLY_RADIUS: radius_ff <= csr_data[6:0];
               default: ;
            endcase
         end
         if (state_ff == wwst_pkg::ST_IDLE && q_take && !q_item.mode
             && w_eff != 0 && h_eff != 0) begin
            if ({3'b0, col_ff} >= w_eff || {3'b0, row_ff} >= h_eff) begin
               col_ff <= '0;
               row_ff <= '0;
               rsum_ff <= {8'b0, q_item.cell_value};
            end else begin
               rsum_ff <= rsum_ff + {8'b0, q_item.cell_value};
            end
         end
         if (state_ff == wwst_pkg::ST_LOAD_WR) begin
            if ({3'b0, col_ff} + 11'd1 >= w_eff) begin
               col_ff <= '0;
               rsum_ff <= '0;
               row_ff <= ({3'b0, row_ff} + 11'd1 >= h_eff) ? '0 : row_ff + RW'(1);
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
         if (state_ff == wwst_pkg::ST_Q_DONE) begin
            res_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_take) begin
         item_ff <= q_item;
         spx_ff <= (spxr > w_eff) ? w_eff : spxr;
         spy_ff <= (spyr > h_eff) ? h_eff : spyr;
         // A negative origin is lifted by 256 map widths before the remainder steps.
         if (rawx < 0) begin
            mx_ff <= 17'(rawx) + {w_eff[8:0], 8'b0};
         end else begin
            mx_ff <= 17'(rawx);
         end
         if (rawy < 0) begin
            my_ff <= 17'(rawy) + {h_eff[8:0], 8'b0};
         end else begin
            my_ff <= 17'(rawy);
         end
         dx_ff <= {w_eff[8:0], 8'b0};
         dy_ff <= {h_eff[8:0], 8'b0};
         mstep_ff <= '0;
         k_ff <= '0;
         acc_ff <= '0;
      end
      if (state_ff == wwst_pkg::ST_Q_MOD) begin
         if (mx_ff >= dx_ff) begin
            mx_ff <= mx_ff - dx_ff;
         end
         if (my_ff >= dy_ff) begin
            my_ff <= my_ff - dy_ff;
         end
         dx_ff <= dx_ff >> 1;
         dy_ff <= dy_ff >> 1;
         mstep_ff <= mstep_ff + 4'd1;
      end
      if (state_ff == wwst_pkg::ST_Q_PREP) begin
         sx_ff <= mxs;
         sy_ff <= mys;
         fw_ff <= (spx_ff < w_eff - mxs) ? spx_ff : w_eff - mxs;
         fh_ff <= (spy_ff < h_eff - mys) ? spy_ff : h_eff - mys;
      end
      if (state_ff == wwst_pkg::ST_Q_RD) begin
         hit_ff <= cr_hit;
         neg_ff <= cc_hit;
      end
      if (state_ff == wwst_pkg::ST_Q_ACC) begin
         if (hit_ff) begin
            acc_ff <= neg_ff ? acc_ff - rd_data : acc_ff + rd_data;
         end
         k_ff <= k_ff + 4'd1;
      end
      if (state_ff == wwst_pkg::ST_Q_DONE) begin
         res_ff <= (item_ff.mode && w_eff != 0 && h_eff != 0) ? acc_ff : '0;
      end
   end
endmodule

@@ sv/wrapped_window_sum_table_unit.sv @@
`timescale 1ns / 1ps
// Wrapped window sum unit over a summed-area table.
// Input beats enter through req_push/req_full. A load beat (req_mode 0) adds
// the next raster cell to the table; a query beat (req_mode 1) yields one
// result beat on the rsp_ side, shown while rsp_empty is low and taken by
// rsp_pop. Loads produce no result.
// A two-entry queue decouples acceptance from execution in the back end,
// which owns the single table memory (one write and one registered read port).
// A load occupies the back end through take, read above, wait and write. A
// query runs through take, nine remainder steps that wrap the window origin,
// setup, sixteen corner reads (each a read and an accumulate step) and finish.
// With the back end idle, rsp_empty falls once the finish step registers the
// result; the next query waits until that result is popped.
// Configuration is written through csr_write, csr_index and csr_data while
// idle; writing map width or height restarts loading at the first cell.
// Reset clears the control state and restores map 256 x 256, radius 12;
// the table contents are undefined until loaded, with no clearing pass.
// When the receiver does not pop, the result is held; loads run until a query
// heads the queue; that query waits and req_full rises once the queue fills.
module wrapped_window_sum_table_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic                       req_mode,
   input  logic [31:0]                req_cell_value,
   input  logic [7:0]                 req_site_x,
   input  logic [7:0]                 req_site_y,
   input  logic signed [5:0]          req_offset_x,
   input  logic signed [5:0]          req_offset_y,
   input  logic [5:0]                 req_foot_width,
   input  logic [5:0]                 req_foot_height,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [47:0]                rsp_window_sum,
   input  logic                       csr_write,
   input  logic [1:0]                 csr_index,
   input  logic [wwst_pkg::CSR_W-1:0] csr_data
);
   wwst_pkg::item_type in_item, q_item;
   logic q_valid, q_take, out_valid;

   assign in_item = '{mode: req_mode, cell_value: req_cell_value, site_x: req_site_x,
                      site_y: req_site_y, offset_x: req_offset_x,
                      offset_y: req_offset_y, foot_width: req_foot_width,
                      foot_height: req_foot_height};
   assign rsp_empty = !out_valid;

   wwst_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_push), .in_full(req_full),
      .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
   );

   wwst_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_item(q_item), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .out_valid(out_valid), .out_sum(rsp_window_sum),
      .out_pop(rsp_pop)
   );
endmodule

@@ sv/wwst_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wwst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        req_mode,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [47:0] rsp_window_sum
);
   `CHECK_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_window_sum))
   `CHECK_IMPL(a_flags_known, clock, reset, req_push || !req_push || req_mode, !$isunknown({req_full, rsp_empty}))
   `CHECK_NEXT(a_pop_clears, clock, reset, !rsp_empty && rsp_pop, rsp_empty)
endmodule

bind wrapped_window_sum_table_unit wwst_checker u_wwst_checker (
   .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
   .req_mode(req_mode), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
   .rsp_window_sum(rsp_window_sum)
);

@@ dv/tb_wrapped_window_sum_table_unit.sv @@
`timescale 1ns / 1ps
module tb_wrapped_window_sum_table_unit;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 48;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_mode = 1'b0;
   logic [31:0] req_cell_value = '0;
   logic [7:0] req_site_x = '0;
   logic [7:0] req_site_y = '0;
   logic signed [5:0] req_offset_x = '0;
   logic signed [5:0] req_offset_y = '0;
   logic [5:0] req_foot_width = '0;
   logic [5:0] req_foot_height = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [47:0] rsp_window_sum;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = wwst_pkg::CSR_MAP_WIDTH;
   logic [wwst_pkg::CSR_W-1:0] csr_data = '0;

   wrapped_window_sum_table_unit i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_mode(req_mode),
      .req_cell_value(req_cell_value), .req_site_x(req_site_x),
      .req_site_y(req_site_y), .req_offset_x(req_offset_x),
      .req_offset_y(req_offset_y), .req_foot_width(req_foot_width),
      .req_foot_height(req_foot_height), .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop), .rsp_window_sum(rsp_window_sum),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state.
   bit [47:0] sat [0:wwst_pkg::DEPTH-1];
   bit [39:0] row_acc;
   int load_col, load_row;
   int cfg_width, cfg_height, cfg_radius;

   wwst_pkg::item_type pending_beats[$];
   bit [47:0] sums_due[$];
   wwst_pkg::item_type cur;
   bit holding = 0;
   int errors = 0;
   int cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int beats_queued = 0;

   function automatic int eff_w();
      return cfg_width > wwst_pkg::MAX_MAP_WIDTH ? wwst_pkg::MAX_MAP_WIDTH : cfg_width;
   endfunction

   function automatic int eff_h();
      return cfg_height > wwst_pkg::MAX_MAP_HEIGHT ? wwst_pkg::MAX_MAP_HEIGHT : cfg_height;
   endfunction

   function automatic bit [47:0] corner_sum(int r, int c);
      if (r == 0 || c == 0 || r > wwst_pkg::MAX_MAP_HEIGHT || c > wwst_pkg::MAX_MAP_WIDTH)
         return '0;
      return sat[(r - 1) * wwst_pkg::MAX_MAP_WIDTH + (c - 1)];
   endfunction

   function automatic bit [47:0] box_sum(int x0, int y0, int w, int h);
      if (w <= 0 || h <= 0) return '0;
      return corner_sum(y0 + h, x0 + w) - corner_sum(y0, x0 + w)
         - corner_sum(y0 + h, x0) + corner_sum(y0, x0);
   endfunction

   function automatic int wrap_to(int v, int n);
      int r;
      r = v % n;
      return r < 0 ? r + n : r;
   endfunction

   task automatic apply_load(bit [31:0] value);
      int w;
      int h;
      w = eff_w();
      h = eff_h();
      if (w == 0 || h == 0) return;
      if (load_col >= w || load_row >= h) begin
         load_col = 0;
         load_row = 0;
         row_acc = '0;
      end
      row_acc = row_acc + value;
      sat[load_row * wwst_pkg::MAX_MAP_WIDTH + load_col] =
         corner_sum(load_row, load_col + 1) + 48'(row_acc);
      load_col++;
      if (load_col >= w) begin
         load_col = 0;
         row_acc = '0;
         load_row++;
         if (load_row >= h) load_row = 0;
      end
   endtask

   function automatic bit [47:0] window_total(wwst_pkg::item_type it);
      int w, h, reach, span_x, span_y, sx, sy, fw, fh;
      bit [47:0] total;
      w = eff_w();
      h = eff_h();
      if (w == 0 || h == 0) return '0;
      reach = cfg_radius + 1;
      span_x = int'(it.foot_width) + 2 * reach;
      span_y = int'(it.foot_height) + 2 * reach;
      if (span_x > w) span_x = w;
      if (span_y > h) span_y = h;
      sx = wrap_to(int'(it.site_x) + int'($signed(it.offset_x)) - reach, w);
      sy = wrap_to(int'(it.site_y) + int'($signed(it.offset_y)) - reach, h);
      fw = span_x < w - sx ? span_x : w - sx;
      fh = span_y < h - sy ? span_y : h - sy;
      total = box_sum(sx, sy, fw, fh) + box_sum(0, sy, span_x - fw, fh)
         + box_sum(sx, 0, fw, span_y - fh) + box_sum(0, 0, span_x - fw, span_y - fh);
      return total;
   endfunction

   // Prediction, result checking and the cycle limit, all at the rising edge.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("wrapped_window_sum_table_unit regression: fail");
         $finish;
      end
      if (reset) begin
         row_acc = '0;
         load_col = 0;
         load_row = 0;
         cfg_width = 256;
         cfg_height = 256;
         cfg_radius = 12;
      end else begin
         if (csr_write) begin
            if (csr_index == wwst_pkg::CSR_SUPPLY_RADIUS) begin
               cfg_radius = int'(csr_data[6:0]);
            end else if (csr_index == wwst_pkg::CSR_MAP_WIDTH
                         || csr_index == wwst_pkg::CSR_MAP_HEIGHT) begin
               if (csr_index == wwst_pkg::CSR_MAP_WIDTH) cfg_width = int'(csr_data);
               else cfg_height = int'(csr_data);
               load_col = 0;
               load_row = 0;
               row_acc = '0;
            end
         end
         if (req_push && !req_full) begin
            holding = 0;
            if (cur.mode) sums_due = {sums_due, window_total(cur)};
            else apply_load(cur.cell_value);
         end
         if (rsp_pop && !rsp_empty) begin
            if (sums_due.size() == 0) begin
               errors++;
               $display("%0t: result beat with no query waiting, actual %h", $time,
                  rsp_window_sum);
            end else if (rsp_window_sum !== sums_due[0]) begin
               errors++;
               $display("%0t: window_sum expected %h actual %h", $time, sums_due[0],
                  rsp_window_sum);
               void'(sums_due.pop_front());
            end else begin
               void'(sums_due.pop_front());
            end
         end
      end
   end

   // Sender: bursts of beats separated by random gaps.
   always @(negedge clock) begin
      if (!reset && !holding) begin
         if (gap_left > 0) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            cur = pending_beats.pop_front();
            holding = 1;
            req_mode <= cur.mode;
            req_cell_value <= cur.cell_value;
            req_site_x <= cur.site_x;
            req_site_y <= cur.site_y;
            req_offset_x <= cur.offset_x;
            req_offset_y <= cur.offset_y;
            req_foot_width <= cur.foot_width;
            req_foot_height <= cur.foot_height;
            req_push <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Receiver: the stall pattern is switched at random among four modes.
   always @(negedge clock) begin
      if (cycles % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= 1'($urandom_range(0, 1));
         2: rsp_pop <= (cycles % 16) < 2;
         default: rsp_pop <= ($urandom_range(0, 9) == 0);
      endcase
   end

   function automatic wwst_pkg::item_type noise_beat();
      wwst_pkg::item_type it;
      it.mode = 1'b0;
      it.cell_value = $urandom;
      it.site_x = 8'($urandom);
      it.site_y = 8'($urandom);
      it.offset_x = 6'($urandom);
      it.offset_y = 6'($urandom);
      it.foot_width = 6'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, 32));
      it.foot_height = 6'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, 32));
      return it;
   endfunction

   task automatic queue_load(bit [31:0] value);
      wwst_pkg::item_type it;
      it = noise_beat();
      it.cell_value = value;
      pending_beats = {pending_beats, it};
      beats_queued++;
   endtask

   task automatic queue_query(bit [7:0] x, bit [7:0] y, bit [5:0] ox, bit [5:0] oy,
                              bit [5:0] fw, bit [5:0] fh);
      wwst_pkg::item_type it;
      it = noise_beat();
      it.mode = 1'b1;
      it.site_x = x;
      it.site_y = y;
      it.offset_x = ox;
      it.offset_y = oy;
      it.foot_width = fw;
      it.foot_height = fh;
      pending_beats = {pending_beats, it};
      beats_queued++;
   endtask

   task automatic queue_random_query();
      wwst_pkg::item_type it;
      it = noise_beat();
      queue_query(it.site_x, it.site_y, it.offset_x, it.offset_y, it.foot_width,
         it.foot_height);
   endtask

   function automatic bit [31:0] random_cell();
      case ($urandom_range(0, 5))
         0: return 32'hFFFF_FFFF;
         1: return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_idle();
      while (!(pending_beats.size() == 0 && !holding && sums_due.size() == 0)) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, int value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value[wwst_pkg::CSR_W-1:0];
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(int w, int h, int radius, int mixed);
      int cells;
      wait_idle();
      write_reg(wwst_pkg::CSR_MAP_WIDTH, w);
      write_reg(wwst_pkg::CSR_MAP_HEIGHT, h);
      write_reg(wwst_pkg::CSR_SUPPLY_RADIUS, radius);
      cells = (w > wwst_pkg::MAX_MAP_WIDTH ? wwst_pkg::MAX_MAP_WIDTH : w)
            * (h > wwst_pkg::MAX_MAP_HEIGHT ? wwst_pkg::MAX_MAP_HEIGHT : h);
      for (int i = 0; i < cells; i++) queue_load(random_cell());
      for (int i = 0; i < mixed; i++) begin
         if ($urandom_range(0, 6) == 0) queue_load(random_cell());
         else queue_random_query();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: tiny map with extreme cells and extreme query fields.
      wait_idle();
      write_reg(wwst_pkg::CSR_MAP_WIDTH, 4);
      write_reg(wwst_pkg::CSR_MAP_HEIGHT, 3);
      write_reg(wwst_pkg::CSR_SUPPLY_RADIUS, 0);
      for (int i = 0; i < 12; i++) queue_load(i % 2 ? 32'hFFFF_FFFF : 32'h0);
      queue_query(8'd0, 8'd0, 6'd0, 6'd0, 6'd0, 6'd0);
      queue_query(8'd255, 8'd255, 6'h20, 6'h1F, 6'd0, 6'd0);
      queue_query(8'd3, 8'd2, 6'h1F, 6'h20, 6'd1, 6'd1);
      queue_query(8'd1, 8'd1, 6'd0, 6'd0, 6'd32, 6'd32);
      queue_query(8'd2, 8'd0, 6'h3F, 6'd0, 6'd63, 6'd0);
      queue_load(32'd5);

      // Zero map size: loads are ignored and queries answer zero.
      wait_idle();
      write_reg(wwst_pkg::CSR_MAP_WIDTH, 0);
      queue_load(32'hFFFF_FFFF);
      queue_query(8'd7, 8'd9, 6'd3, 6'd3, 6'd4, 6'd4);
      wait_idle();
      write_reg(wwst_pkg::CSR_MAP_WIDTH, 5);
      write_reg(wwst_pkg::CSR_MAP_HEIGHT, 0);
      queue_query(8'd1, 8'd2, 6'd0, 6'd0, 6'd1, 6'd1);

      // Size extremes, including values above the maximum and the widest radius.
      run_phase(511, 1, 127, 30);
      run_phase(2, 256, 0, 30);
      run_phase(1, 300, 12, 20);
      run_phase(1, 1, 127, 15);

      while (beats_queued < 1620) begin
         run_phase($urandom_range(1, 12), $urandom_range(1, 12),
            ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(0, 20), 50);
      end

      wait_idle();
      if (errors == 0) begin
         $display("wrapped_window_sum_table_unit regression: pass");
      end else begin
         $display("wrapped_window_sum_table_unit regression: fail");
      end
      $finish;
   end
endmodule

@@ wrapped_window_sum_table_unit.f @@
+incdir+sv
sv/wwst_pkg.sv
sv/wwst_ram.sv
sv/wwst_front.sv
sv/wwst_back.sv
sv/wrapped_window_sum_table_unit.sv
sv/wwst_checker.sv
dv/tb_wrapped_window_sum_table_unit.sv
